// ===== rtl/hpsc_pkg.sv =====
// Shared types and constants for the H.264 parameter set capture block.
// No dependencies; rtl/h264_parameter_set_capture.sv and dv/testbench.sv import this package.
`timescale 1ns / 1ps

package hpsc_pkg;

    // Capture target codes
    typedef logic [1:0] target_t;
    localparam target_t TGT_NONE = 2'd0;
    localparam target_t TGT_SPS  = 2'd1;
    localparam target_t TGT_PPS  = 2'd2;

    // Operation codes carried in tuser bit 0
    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Buffer select codes carried in tuser bit 1
    localparam logic BUF_SEL_SPS = 1'b0;
    localparam logic BUF_SEL_PPS = 1'b1;

    // NAL header fields
    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

    // Store is split into interleaved byte banks so that one word can write
    // up to five consecutive bytes at once
    localparam int NUM_BANKS = 8;
    localparam int BANK_W    = 3;

endpackage

// ===== rtl/h264_parameter_set_capture.sv =====
// Top level of the H.264 parameter set capture block: start code scan,
// delay line, banked SPS/PPS stores and result register. Depends on hpsc_pkg.
`timescale 1ns / 1ps

// Scans an H.264 Annex B frame one byte per word and keeps the latest SPS and
// PPS NAL units (start code included) in two capture buffers of BUF_DEPTH
// bytes. A stream word (tuser operation = 0) carries one frame byte, with
// tlast on the frame's last byte; its result carries read_data = 0, the
// committed SPS/PPS lengths, cache_ready, and on the last byte frame_done
// (tlast) with keyframe set when the frame held a NAL of type 5 or 7. A read
// word (operation = 1) returns the cached byte at read_index of the selected
// buffer, or 0 beyond the committed length. Lengths are committed when a NAL
// ends; a NAL that outgrows the buffer is truncated and overflow stays set
// until reset. The block takes one word per cycle while the result side is
// not stalled, and every word yields one result: it passes the input register,
// where the delay-line update, the bank write enables and the store read
// address are worked out, and then the result register. The stores are
// eight interleaved byte banks, each with one write and one read port, so
// the up to five bytes that a single word can release are written in the
// same cycle. The stores need no clearing after reset: only positions below
// a committed length are ever returned.
module h264_parameter_set_capture #(
    parameter int BUF_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] read_index
    input  logic [1:0]  s_tuser,   // [0] operation, [1] which_buffer
    input  logic        s_tlast,   // last_byte
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] read_data, [16:8] sps_length,
                                   // [25:17] pps_length, [26] cache_ready,
                                   // [27] keyframe, [28] overflow, [31:29] zero
    output logic        m_tlast    // frame_done
);
    import hpsc_pkg::*;

    localparam int PTR_W      = $clog2(BUF_DEPTH + 1);
    localparam int SUM_W      = PTR_W + 1;
    localparam int AW         = PTR_W + 8;
    localparam int BANK_DEPTH = (BUF_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             in_buf_reg;
    logic [7:0]       in_idx_reg;

    logic             advance;
    logic             step;
    logic             out_valid_reg;

    // Advance the input word into the result register when that slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign step     = advance && (in_op_reg == OP_STREAM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser[0];
            in_buf_reg  <= s_tuser[1];
            in_byte_reg <= s_tdata[7:0];
            in_idx_reg  <= s_tdata[15:8];
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [7:0]       dly_reg [4];
    logic [7:0]       dly_next [4];
    logic [2:0]       cnt_reg, cnt_next;
    logic             await_reg, await_next;
    target_t          tgt_reg, tgt_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] sps_cnt_reg, sps_cnt_next;
    logic [PTR_W-1:0] pps_cnt_reg, pps_cnt_next;
    logic             key_reg, key_next;
    logic             ovf_reg, ovf_next;

    // Step working signals
    logic [7:0]       line [4];      // delay line after this byte is shifted in
    logic [2:0]       cnt_line;
    logic             pre_put;       // oldest byte leaves a full delay line
    logic [2:0]       m2, m3;
    logic             det;           // start code completes on this byte
    logic             sc4;           // four-byte start code
    logic             older;         // one byte ahead of the start code
    logic [4:0]       hdr_type;
    target_t          new_tgt;
    target_t          tgt_w;         // target that receives this word's bytes
    logic [7:0]       seq [NUM_BANKS];
    logic [2:0]       nput;
    logic [2:0]       flush_n;
    logic [PTR_W-1:0] base;
    logic [SUM_W-1:0] sum_end;
    logic [PTR_W-1:0] wp_after;
    logic             ovf_set;
    logic             key_now;

    always_comb
    begin
        hdr_type = in_byte_reg[4:0] & NAL_TYPE_MASK;
        if (hdr_type == NAL_TYPE_SPS)
            new_tgt = TGT_SPS;
        else if (hdr_type == NAL_TYPE_PPS)
            new_tgt = TGT_PPS;
        else
            new_tgt = TGT_NONE;

        // Shift the new byte into the delay line
        line = dly_reg;
        if (cnt_reg == 3'd4)
        begin
            pre_put  = 1'b1;
            line[0]  = dly_reg[1];
            line[1]  = dly_reg[2];
            line[2]  = dly_reg[3];
            line[3]  = in_byte_reg;
            cnt_line = 3'd4;
        end
        else
        begin
            pre_put  = 1'b0;
            line[cnt_reg[1:0]] = in_byte_reg;
            cnt_line = cnt_reg + 3'd1;
        end

        // Start code detection on the tail of the line
        m2    = cnt_line - 3'd2;
        m3    = cnt_line - 3'd3;
        det   = (in_byte_reg == 8'h01) && (cnt_line >= 3'd3)
                && (line[m2[1:0]] == 8'h00) && (line[m3[1:0]] == 8'h00);
        sc4   = (cnt_line == 3'd4) && (line[0] == 8'h00);
        older = det && (cnt_line == 3'd4) && !sc4;

        // Bytes released by this word, in store order
        for (int k = 0; k < NUM_BANKS; k++)
            seq[k] = 8'h00;
        if (await_reg)
        begin
            // Header byte: the held start code, then the header itself
            for (int k = 0; k < 4; k++)
                seq[k] = (3'(k) < cnt_reg) ? dly_reg[k] : in_byte_reg;
            seq[4]  = in_byte_reg;
            flush_n = 3'd0;
            nput    = cnt_reg + 3'd1;
        end
        else
        begin
            if (det)
                flush_n = {2'b00, older};
            else if (in_last_reg)
                flush_n = cnt_line;
            else
                flush_n = 3'd0;
            if (pre_put)
            begin
                seq[0] = dly_reg[0];
                for (int k = 0; k < 4; k++)
                    seq[k + 1] = line[k];
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                    seq[k] = line[k];
            end
            nput = flush_n + {2'b00, pre_put};
        end

        tgt_w    = await_reg ? new_tgt : tgt_reg;
        base     = await_reg ? '0 : wp_reg;
        sum_end  = SUM_W'(base) + SUM_W'(nput);
        ovf_set  = (tgt_w != TGT_NONE) && (sum_end > SUM_W'(BUF_DEPTH));
        if (tgt_w == TGT_NONE)
            wp_after = base;
        else if (sum_end > SUM_W'(BUF_DEPTH))
            wp_after = PTR_W'(BUF_DEPTH);
        else
            wp_after = sum_end[PTR_W-1:0];

        // Commit lengths: the NAL closed by a header, then the frame end
        sps_cnt_next = sps_cnt_reg;
        pps_cnt_next = pps_cnt_reg;
        if (await_reg)
        begin
            if (tgt_reg == TGT_SPS)
                sps_cnt_next = wp_reg;
            else if (tgt_reg == TGT_PPS)
                pps_cnt_next = wp_reg;
        end
        if (in_last_reg)
        begin
            if (tgt_w == TGT_SPS)
                sps_cnt_next = wp_after;
            else if (tgt_w == TGT_PPS)
                pps_cnt_next = wp_after;
        end

        key_now = key_reg || (await_reg
                  && ((hdr_type == NAL_TYPE_IDR) || (hdr_type == NAL_TYPE_SPS)));
        key_next = in_last_reg ? 1'b0 : key_now;
        ovf_next = ovf_reg || ovf_set;

        dly_next = line;
        if (in_last_reg)
        begin
            // Frame end: flush and drop any pending start code
            tgt_next   = TGT_NONE;
            wp_next    = '0;
            cnt_next   = 3'd0;
            await_next = 1'b0;
        end
        else if (await_reg)
        begin
            tgt_next   = new_tgt;
            wp_next    = wp_after;
            cnt_next   = 3'd0;
            await_next = 1'b0;
        end
        else
        begin
            tgt_next = tgt_reg;
            wp_next  = wp_after;
            if (det)
            begin
                // Hold only the start code
                if (older)
                begin
                    dly_next[0] = line[1];
                    dly_next[1] = line[2];
                    dly_next[2] = line[3];
                end
                cnt_next   = sc4 ? 3'd4 : 3'd3;
                await_next = 1'b1;
            end
            else
            begin
                cnt_next   = cnt_line;
                await_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 3'd0;
            await_reg   <= 1'b0;
            tgt_reg     <= TGT_NONE;
            wp_reg      <= '0;
            sps_cnt_reg <= '0;
            pps_cnt_reg <= '0;
            key_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (step)
        begin
            cnt_reg     <= cnt_next;
            await_reg   <= await_next;
            tgt_reg     <= tgt_next;
            wp_reg      <= wp_next;
            sps_cnt_reg <= sps_cnt_next;
            pps_cnt_reg <= pps_cnt_next;
            key_reg     <= key_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dly_reg <= dly_next;
        end
    end

    // ------------------------------------------------------------------
    // Banked stores: byte address a lives in bank a[2:0], row a >> 3
    // ------------------------------------------------------------------
    logic             wr_en   [NUM_BANKS];
    logic [ROW_W-1:0] wr_row  [NUM_BANKS];
    logic [7:0]       wr_data [NUM_BANKS];
    logic [BANK_W-1:0] wr_k   [NUM_BANKS];
    logic [SUM_W-1:0] wr_addr [NUM_BANKS];
    logic             wr_buf;

    always_comb
    begin
        wr_buf = (tgt_w == TGT_PPS);
        for (int j = 0; j < NUM_BANKS; j++)
        begin
            wr_k[j]    = BANK_W'(j) - base[BANK_W-1:0];
            wr_addr[j] = SUM_W'(base) + SUM_W'(wr_k[j]);
            wr_en[j]   = step && (tgt_w != TGT_NONE) && (wr_k[j] < nput)
                         && (wr_addr[j] < SUM_W'(BUF_DEPTH));
            wr_row[j]  = wr_addr[j][BANK_W +: ROW_W];
            wr_data[j] = seq[wr_k[j]];
        end
    end

    logic [AW-1:0]    idx_wide;
    logic [ROW_W-1:0] rd_row;
    logic             rd_hit;
    logic [7:0]       bank_q [NUM_BANKS];

    always_comb
    begin
        idx_wide = AW'(in_idx_reg);
        rd_row   = idx_wide[BANK_W +: ROW_W];
        if (in_buf_reg == BUF_SEL_PPS)
            rd_hit = idx_wide < AW'(pps_cnt_reg);
        else
            rd_hit = idx_wide < AW'(sps_cnt_reg);
        rd_hit = rd_hit && (idx_wide < AW'(BUF_DEPTH));
    end

    for (genvar j = 0; j < NUM_BANKS; j++)
    begin : g_bank
        logic [7:0] mem [0:1][0:BANK_DEPTH-1];

        always_ff @(posedge clk)
        begin
            if (wr_en[j])
            begin
                mem[wr_buf][wr_row[j]] <= wr_data[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance && (in_op_reg == OP_READ))
            begin
                bank_q[j] <= mem[in_buf_reg][rd_row];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. Lengths and overflow come straight from the state:
    // the state cannot move on while a result waits.
    // ------------------------------------------------------------------
    logic              rd_hit_reg;
    logic [BANK_W-1:0] rd_bank_reg;
    logic              done_reg;
    logic              key_out_reg;
    logic [7:0]        read_data;
    logic [AW-1:0]     sps_wide, pps_wide;
    logic              cache_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_hit_reg  <= (in_op_reg == OP_READ) && rd_hit;
            rd_bank_reg <= in_idx_reg[BANK_W-1:0];
            done_reg    <= (in_op_reg == OP_STREAM) && in_last_reg;
            key_out_reg <= (in_op_reg == OP_STREAM) && in_last_reg && key_now;
        end
    end

    always_comb
    begin
        read_data   = rd_hit_reg ? bank_q[rd_bank_reg] : 8'h00;
        sps_wide    = AW'(sps_cnt_reg);
        pps_wide    = AW'(pps_cnt_reg);
        cache_ready = (sps_cnt_reg != '0) && (pps_cnt_reg != '0);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {3'b000, ovf_reg, key_out_reg, cache_ready,
                       pps_wide[8:0], sps_wide[8:0], read_data};

endmodule

// ===== rtl/hpsc_checker.sv =====
// Port-level checker for the H.264 parameter set capture block and the bind
// that attaches it. Sees only the top level's ports; no package dependency.
`timescale 1ns / 1ps

module hpsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    logic ovf_seen_reg;

    // Remember an overflow once a result has shown it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tdata[28])
        begin
            ovf_seen_reg <= 1'b1;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Keyframe is only reported with frame end
    a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |-> m_tlast)
        else $error("keyframe without frame_done");

    // Overflow is sticky until reset
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ovf_seen_reg |-> m_tdata[28])
        else $error("overflow flag cleared");

endmodule

bind h264_parameter_set_capture hpsc_checker u_hpsc_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking bench for h264_parameter_set_capture: streams Annex B frames and read words,
// predicts every status word in-bench, checks the whole word and reports it field by field. Depends on hpsc_pkg.
`timescale 1ns / 1ps

module testbench;
    import hpsc_pkg::*;

    localparam int CAP_DEPTH    = 256;
    localparam int RANDOM_WORDS = 700;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int MAX_REPORTS  = 10;

    // Ordinary non-IDR slice
    localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;

    // One result word as it leaves the block: {m_tlast, m_tdata}
    typedef struct packed {
        logic       frame_done;
        logic [2:0] pad;
        logic       overflow;
        logic       keyframe;
        logic       cache_ready;
        logic [8:0] pps_length;
        logic [8:0] sps_length;
        logic [7:0] read_data;
    } status_t;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] data_byte, [15:8] read_index
    logic [1:0]  s_tuser  = '0;   // [0] operation, [1] which_buffer
    logic        s_tlast  = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [7:0] read_data, [16:8] sps_length, [25:17] pps_length,
                                  // [26] cache_ready, [27] keyframe, [28] overflow, [31:29] 0
    logic        m_tlast;         // frame_done

    h264_parameter_set_capture #(
        .BUF_DEPTH(CAP_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Capture tracker: the bench's own copy of the parser state
    // ------------------------------------------------------------------
    bit [7:0]    held [4];        // delay line, oldest byte first
    int unsigned held_cnt;
    target_t     cap_tgt = TGT_NONE;
    bit          hdr_pending;     // a start code was seen, the next byte is the NAL header
    int unsigned wr_ptr;
    bit [7:0]    sps_mem [CAP_DEPTH];
    bit [7:0]    pps_mem [CAP_DEPTH];
    bit [8:0]    sps_len;
    bit [8:0]    pps_len;
    bit          key_seen;
    bit          ovf_seen;

    status_t capture_status_q[$];  // status words still owed by the block

    // Run bookkeeping
    int  words_sent;
    int  reads_sent;
    int  mismatches;
    int  frames_seen;
    int  keyframes_seen;
    bit  overflow_hit;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    int  hold_request;            // receiver hold-off length, picked up by the ready driver

    // Store one released byte into the buffer of the open NAL; drop it past the end
    function automatic void keep_byte(bit [7:0] b);
        if (cap_tgt != TGT_NONE)
        begin
            if (wr_ptr < CAP_DEPTH)
            begin
                if (cap_tgt == TGT_SPS)
                    sps_mem[wr_ptr] = b;
                else
                    pps_mem[wr_ptr] = b;
                wr_ptr++;
            end
            else
                ovf_seen = 1'b1;
        end
    endfunction

    function automatic void close_nal();
        if (cap_tgt == TGT_SPS)
            sps_len = wr_ptr[8:0];
        else if (cap_tgt == TGT_PPS)
            pps_len = wr_ptr[8:0];
    endfunction

    function automatic void scan_byte(bit [7:0] b);
        bit [4:0]    hdr_type;
        int unsigned sc_len;
        int unsigned older;
        if (hdr_pending)
        begin
            // header byte: commit the previous NAL, open the new one and
            // release the start code into it
            hdr_type = b[4:0] & NAL_TYPE_MASK;
            close_nal();
            if (hdr_type == NAL_TYPE_SPS)
                cap_tgt = TGT_SPS;
            else if (hdr_type == NAL_TYPE_PPS)
                cap_tgt = TGT_PPS;
            else
                cap_tgt = TGT_NONE;
            wr_ptr = 0;
            for (int k = 0; k < held_cnt; k++)
                keep_byte(held[k]);
            keep_byte(b);
            held_cnt    = 0;
            hdr_pending = 1'b0;
            if (hdr_type == NAL_TYPE_IDR || hdr_type == NAL_TYPE_SPS)
                key_seen = 1'b1;
        end
        else
        begin
            if (held_cnt >= 4)
            begin
                keep_byte(held[0]);
                held[0]  = held[1];
                held[1]  = held[2];
                held[2]  = held[3];
                held_cnt = 3;
            end
            held[held_cnt] = b;
            held_cnt++;
            if (b == 8'h01 && held_cnt >= 3 && held[held_cnt-2] == 8'h00 &&
                held[held_cnt-3] == 8'h00)
            begin
                sc_len = (held_cnt >= 4 && held[held_cnt-4] == 8'h00) ? 4 : 3;
                older  = held_cnt - sc_len;
                for (int k = 0; k < older; k++)
                    keep_byte(held[k]);
                for (int k = 0; k < sc_len; k++)
                    held[k] = held[k+older];
                held_cnt    = sc_len;
                hdr_pending = 1'b1;
            end
        end
    endfunction

    function automatic void flush_frame();
        if (!hdr_pending)
            for (int k = 0; k < held_cnt; k++)
                keep_byte(held[k]);
        close_nal();
        cap_tgt     = TGT_NONE;
        wr_ptr      = 0;
        held_cnt    = 0;
        hdr_pending = 1'b0;
        for (int k = 0; k < 4; k++)
            held[k] = 8'h00;
    endfunction

    // Advance the tracker by one accepted word and return the status it owes
    function automatic status_t track_capture(logic op, logic [7:0] data, logic tail,
                                              logic which, logic [7:0] idx);
        status_t s;
        s = '0;
        if (op == OP_READ)
        begin
            if (which == BUF_SEL_SPS)
            begin
                if (idx < sps_len)
                    s.read_data = sps_mem[idx];
            end
            else if (idx < pps_len)
                s.read_data = pps_mem[idx];
        end
        else
        begin
            scan_byte(data);
            if (tail)
            begin
                flush_frame();
                s.frame_done = 1'b1;
                s.keyframe   = key_seen;
                key_seen     = 1'b0;
            end
        end
        s.sps_length  = sps_len;
        s.pps_length  = pps_len;
        s.cache_ready = (sps_len != 0) && (pps_len != 0);
        s.overflow    = ovf_seen;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input logic op, input logic [7:0] data, input logic tail,
                             input logic which, input logic [7:0] idx);
        int gap;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, data};
        s_tuser  <= {which, op};
        s_tlast  <= tail;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        capture_status_q = {capture_status_q, track_capture(op, data, tail, which, idx)};
        words_sent++;
        if (op == OP_READ)
            reads_sent++;
    endtask

    // Read word: data_byte and last_byte are don't-care, so randomize them
    task automatic send_read(input logic which, input logic [7:0] idx);
        send_word(OP_READ, 8'($urandom), 1'($urandom), which, idx);
    endtask

    // Mostly inside the committed length, sometimes anywhere
    function automatic logic [7:0] read_pick(logic which);
        int len;
        len = (which == BUF_SEL_SPS) ? sps_len : pps_len;
        if (len > 0 && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, len - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Stream byte, sometimes preceded by a read of either buffer
    task automatic feed_byte(input logic [7:0] b, input logic tail);
        logic which;
        if ($urandom_range(0, 7) == 0)
        begin
            which = 1'($urandom);
            send_read(which, read_pick(which));
        end
        send_word(OP_STREAM, b, tail, 1'($urandom), 8'($urandom));
    endtask

    // Send a whole frame as given, tlast on its final byte
    task automatic send_frame_bytes(input byte_q_t bytes);
        for (int i = 0; i < bytes.size(); i++)
            send_word(OP_STREAM, bytes[i], i == bytes.size() - 1, 1'($urandom), 8'($urandom));
    endtask

    // Payload with extra zeros and ones so partial start codes show up
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        else if (r == 2)
            return 8'h01;
        return 8'($urandom);
    endfunction

    function automatic logic [4:0] pick_nal_type();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return NAL_TYPE_SPS;
        else if (r < 6)
            return NAL_TYPE_PPS;
        else if (r < 8)
            return NAL_TYPE_IDR;
        else if (r == 8)
            return NAL_TYPE_SLICE;
        return 5'($urandom);
    endfunction

    // Lower valid and wait until every owed status word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (capture_status_q.size() != 0)
            @(posedge clk);
    endtask

    // Well-formed frame: optional junk, one to four NALs, then an ordinary
    // byte, a dangling start code or a start code cut short as the last byte
    task automatic send_random_frame();
        int nals;
        int plen;
        int r;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) feed_byte(payload_byte(), 1'b0);
        nals = $urandom_range(1, 4);
        for (int n = 0; n < nals; n++)
        begin
            if ($urandom_range(0, 1) != 0)
                feed_byte(8'h00, 1'b0);
            feed_byte(8'h00, 1'b0);
            feed_byte(8'h00, 1'b0);
            feed_byte(8'h01, 1'b0);
            feed_byte({3'($urandom), pick_nal_type()}, 1'b0);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
            repeat (plen) feed_byte(payload_byte(), 1'b0);
        end
        r = $urandom_range(0, 9);
        if (r < 6)
            feed_byte(payload_byte(), 1'b1);
        else if (r < 8)
        begin
            feed_byte(8'h00, 1'b0);
            feed_byte(8'h00, 1'b0);
            feed_byte(8'h01, 1'b1);
        end
        else
        begin
            feed_byte(8'h00, 1'b0);
            feed_byte(8'h00, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Junk before the first start code, 3- and 4-byte start codes, SPS, PPS,
    // IDR header as the last byte, reads inside and past the committed
    // length, a non-key NAL and a frame ending in a bare start code
    task automatic test_directed();
        byte_q_t frame_a;
        byte_q_t frame_b;
        frame_a = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
                    8'h00, 8'h00, 8'h01, 8'h65};
        frame_b = '{8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01};
        send_read(BUF_SEL_SPS, 8'd0);
        send_frame_bytes(frame_a);
        send_read(BUF_SEL_SPS, 8'd5);
        send_read(BUF_SEL_SPS, 8'd6);
        send_read(BUF_SEL_PPS, 8'd0);
        send_read(BUF_SEL_PPS, 8'd255);
        send_frame_bytes(frame_b);
    endtask

    // An SPS that exactly fills the buffer, then one that runs past it
    task automatic test_overflow();
        byte_q_t bytes;
        bytes = '{8'h00, 8'h00, 8'h01, 8'hE7};
        repeat (CAP_DEPTH - 4) bytes = {bytes, 8'($urandom_range(2, 255))};
        bytes = {bytes, 8'h00};
        bytes = {bytes, 8'h00};
        bytes = {bytes, 8'h01};
        bytes = {bytes, 8'h68};
        bytes = {bytes, 8'hAB};
        bytes = {bytes, 8'hC3};
        send_frame_bytes(bytes);
        send_read(BUF_SEL_SPS, 8'd255);
        send_read(BUF_SEL_PPS, 8'd5);
        bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67};
        repeat (270) bytes = {bytes, 8'($urandom_range(2, 255))};
        send_frame_bytes(bytes);
        send_read(BUF_SEL_SPS, 8'd255);
        send_read(BUF_SEL_SPS, 8'd0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // words back to back; then the sender pauses until all results are in
    task automatic test_backpressure();
        byte_q_t bytes;
        send_idle_on = 1'b0;
        hold_request = 300;
        bytes = '{8'h00, 8'h00, 8'h01, 8'h68};
        repeat (40) bytes = {bytes, payload_byte()};
        bytes = {bytes, 8'h00};
        bytes = {bytes, 8'h00};
        bytes = {bytes, 8'h01};
        bytes = {bytes, 8'h27};
        repeat (20) bytes = {bytes, payload_byte()};
        send_frame_bytes(bytes);
        wait_drained();
        send_read(BUF_SEL_PPS, read_pick(BUF_SEL_PPS));
        send_read(BUF_SEL_SPS, read_pick(BUF_SEL_SPS));
        send_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, the rest raw noise;
    // idling on each side switched per frame
    task automatic test_random_frames();
        int first;
        int n;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS)
        begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 30);
                for (int i = 0; i < n; i++)
                    feed_byte(payload_byte(), i == n - 1);
            end
            else
                send_random_frame();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive m_tready: long hold-off on request, else random stalls
    initial
    begin : result_ready_driver
        int hold_left;
        int stall_left;
        int g;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                g = recv_idle_on ? pick_gap() : 0;
                if (g > 0)
                begin
                    m_tready   <= 1'b0;
                    stall_left = g - 1;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string why, input status_t want, input status_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t %s: exp/act rd %h/%h sps %0d/%0d pps %0d/%0d rdy %b/%b",
                     $realtime, why, want.read_data, got.read_data, want.sps_length,
                     got.sps_length, want.pps_length, got.pps_length, want.cache_ready,
                     got.cache_ready);
            $display("    done %b/%b key %b/%b ovf %b/%b pad %h/%h",
                     want.frame_done, got.frame_done, want.keyframe, got.keyframe,
                     want.overflow, got.overflow, want.pad, got.pad);
        end
    endtask

    // Check each accepted result word against the oldest owed status
    initial
    begin : result_checker
        status_t got;
        status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = {m_tlast, m_tdata};
                if (capture_status_q.size() == 0)
                    note_mismatch("unexpected result", '0, got);
                else
                begin
                    want = capture_status_q.pop_front();
                    if (got !== want)
                        note_mismatch("mismatch", want, got);
                    if (want.frame_done)
                        frames_seen++;
                    if (want.keyframe)
                        keyframes_seen++;
                    if (want.overflow)
                        overflow_hit = 1'b1;
                end
            end
        end
    end

    // End the run when neither side moves a word for too long
    initial
    begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results owed",
                 STALL_LIMIT, capture_status_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_random_frames();

        // Let the pipeline empty, then keep watching for strays before the final check
        wait_drained();
        repeat (8) @(posedge clk);
        if (capture_status_q.size() != 0)
            note_mismatch("result missing", capture_status_q[0], '0);

        $display("covered %0d words (%0d reads), %0d frames, %0d keyframes, overflow %s",
                 words_sent, reads_sent, frames_seen, keyframes_seen,
                 overflow_hit ? "reached" : "not reached");
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hpsc_pkg.sv
rtl/h264_parameter_set_capture.sv
rtl/hpsc_checker.sv
dv/testbench.sv
